// ===== rtl/abs_pkg.sv =====
// package: shared types and constants of the bounding sphere block
package abs_pkg;

  localparam int MaxPoints = 1024;
  localparam int CoordBits = 24;
  localparam int AddrBits  = $clog2(MaxPoints);
  localparam int CntBits   = AddrBits + 1;
  localparam int DiffBits  = CoordBits + 1;
  localparam int SqBits    = 2 * DiffBits;
  localparam int DistBits  = SqBits + 2;
  localparam int RadBits   = CoordBits + 1;
  localparam int RootBits  = DistBits / 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // pass over the store
  typedef enum logic [1:0] {
    PassFar1 = 2'd0,
    PassFar2 = 2'd1,
    PassRad  = 2'd2
  } pass_e;

  typedef struct packed {
    logic  load;
    logic  start_pass;
    pass_e pass;
    logic  scan;
    logic  scan_last;
    logic  set_center;
    logic  sqrt_start;
    logic  sqrt_step;
    logic  clear_set;
  } ctrl_t;

  typedef struct packed {
    logic [CntBits-1:0] count;
  } stat_t;

endpackage

// ===== rtl/abs_datapath.sv =====
// datapath: point store, distance pipeline, search registers, square root
module abs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abs_pkg::ctrl_t         ctrl_i,
  input  abs_pkg::point_t        in_point_i,
  output abs_pkg::stat_t         stat_o,
  output abs_pkg::point_t        center_o,
  output logic [abs_pkg::RadBits-1:0] radius_o,
  output logic                   overflow_o
);

  localparam int Db = abs_pkg::DiffBits;
  localparam int Sb = abs_pkg::SqBits;
  localparam int Tb = abs_pkg::DistBits;
  localparam int Rb = abs_pkg::RootBits;

  abs_pkg::point_t mem_q [abs_pkg::MaxPoints];
  abs_pkg::point_t rd_q;
  logic [abs_pkg::CntBits-1:0] count_q;
  logic [abs_pkg::CntBits-1:0] rd_addr_q;
  logic                        ovf_q;
  abs_pkg::point_t origin_q, far_q, f1_q, center_q;
  logic [Tb-1:0] best_q, dist_q;
  logic [Sb-1:0] sq_q [3];
  abs_pkg::point_t p1_q, p2_q;
  logic v1_q, v2_q, v3_q;
  logic [Tb-1:0] rem_q;
  logic [Tb-1:0] sh_q;
  logic [Rb-1:0] root_q;

  // load and scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (ctrl_i.clear_set) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (ctrl_i.load) begin
        if (count_q < abs_pkg::CntBits'(abs_pkg::MaxPoints)) count_q <= count_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (ctrl_i.start_pass) rd_addr_q <= '0;
      else if (ctrl_i.scan) rd_addr_q <= rd_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && count_q < abs_pkg::CntBits'(abs_pkg::MaxPoints))
      mem_q[count_q[abs_pkg::AddrBits-1:0]] <= in_point_i;
    if (ctrl_i.scan) rd_q <= mem_q[rd_addr_q[abs_pkg::AddrBits-1:0]];
  end

  // distance pipeline: read, difference squares, sum, compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.scan;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [Db-1:0] d0, d1, d2;
    d0 = Db'(rd_q.x) - Db'(origin_q.x);
    d1 = Db'(rd_q.y) - Db'(origin_q.y);
    d2 = Db'(rd_q.z) - Db'(origin_q.z);
    sq_q[0] <= Sb'(d0 * d0);
    sq_q[1] <= Sb'(d1 * d1);
    sq_q[2] <= Sb'(d2 * d2);
    p1_q    <= rd_q;
    dist_q  <= Tb'(sq_q[0]) + Tb'(sq_q[1]) + Tb'(sq_q[2]);
    p2_q    <= p1_q;
  end

  // search registers and center
  always_ff @(posedge clk_i) begin
    logic signed [Db-1:0] s0, s1, s2;
    s0 = Db'(f1_q.x) + Db'(far_q.x);
    s1 = Db'(f1_q.y) + Db'(far_q.y);
    s2 = Db'(f1_q.z) + Db'(far_q.z);
    if (ctrl_i.start_pass) begin
      best_q <= '0;
      case (ctrl_i.pass)
        abs_pkg::PassFar1: begin
          origin_q <= mem_q[0];
          far_q    <= mem_q[0];
        end
        abs_pkg::PassFar2: begin
          origin_q <= far_q;
          f1_q     <= far_q;
        end
        default: origin_q <= center_q;
      endcase
    end else if (v3_q && dist_q > best_q) begin
      best_q <= dist_q;
      if (ctrl_i.pass != abs_pkg::PassRad) far_q <= p2_q;
    end
    if (ctrl_i.set_center) begin
      center_q.x <= abs_pkg::CoordBits'(s0 >>> 1);
      center_q.y <= abs_pkg::CoordBits'(s1 >>> 1);
      center_q.z <= abs_pkg::CoordBits'(s2 >>> 1);
    end
  end

  // restoring square root, one result bit a step
  always_ff @(posedge clk_i) begin
    logic [Tb+1:0] rem2;
    logic [Tb+1:0] trial;
    if (ctrl_i.sqrt_start) begin
      rem_q  <= best_q;
      root_q <= '0;
      sh_q   <= '0;
    end else if (ctrl_i.sqrt_step) begin
      rem2  = {sh_q, rem_q[Tb-1 -: 2]};
      trial = (Tb+2)'({root_q, 2'b01});
      rem_q <= rem_q << 2;
      if (rem2 >= trial) begin
        sh_q   <= Tb'(rem2 - trial);
        root_q <= {root_q[Rb-2:0], 1'b1};
      end else begin
        sh_q   <= Tb'(rem2);
        root_q <= {root_q[Rb-2:0], 1'b0};
      end
    end
  end

  assign stat_o.count = count_q;
  assign center_o   = center_q;
  assign radius_o   = abs_pkg::RadBits'(root_q);
  assign overflow_o = ovf_q;

endmodule

// ===== rtl/abs_ctrl.sv =====
// controller: load, three scan passes, center, square root, result hold
module abs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  input  abs_pkg::stat_t stat_i,
  output abs_pkg::ctrl_t ctrl_o,
  output logic           in_ready_o,
  output logic           out_valid_o
);

  typedef enum logic [6:0] {
    StLoad  = 7'b0000001,
    StStart = 7'b0000010,
    StScan  = 7'b0000100,
    StDrain = 7'b0001000,
    StCent  = 7'b0010000,
    StSqrt  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  localparam int StepBits = $clog2(abs_pkg::RootBits + 1);

  state_e state_q, state_d;
  abs_pkg::pass_e pass_q, pass_d;
  logic [abs_pkg::CntBits-1:0] idx_q, idx_d;
  logic [StepBits-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    idx_d   = idx_q;
    step_d  = step_q;
    ctrl_o  = '0;
    ctrl_o.pass = pass_q;
    case (state_q)
      StLoad: begin
        ctrl_o.load = in_fire_i;
        if (in_fire_i && in_last_i) begin
          state_d = StStart;
          pass_d  = abs_pkg::PassFar1;
        end
      end
      StStart: begin
        ctrl_o.start_pass = 1'b1;
        idx_d   = '0;
        state_d = StScan;
      end
      StScan: begin
        ctrl_o.scan = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == stat_i.count) begin
          state_d = StDrain;
          idx_d   = '0;
        end
      end
      StDrain: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == abs_pkg::CntBits'(3)) begin
          case (pass_q)
            abs_pkg::PassFar1: begin
              pass_d = abs_pkg::PassFar2;
              state_d = StStart;
            end
            abs_pkg::PassFar2: state_d = StCent;
            default: begin
              state_d = StSqrt;
              ctrl_o.sqrt_start = 1'b1;
              step_d = '0;
            end
          endcase
        end
      end
      StCent: begin
        ctrl_o.set_center = 1'b1;
        pass_d  = abs_pkg::PassRad;
        state_d = StStart;
      end
      StSqrt: begin
        ctrl_o.sqrt_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(abs_pkg::RootBits - 1)) state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          ctrl_o.clear_set = 1'b1;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      pass_q  <= abs_pkg::PassFar1;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StOut);

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open while result held");
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> stat_i.count != '0) else $error("scan of empty set");

endmodule

// ===== rtl/approx_bounding_sphere.sv =====
// top level: approximate bounding sphere of a streamed 3-d point set
//
// channel  dir  beat fields (lsb first)
// s_axis   in   tdata: point_x[23:0] point_y[47:24] point_z[71:48]; tlast: last_point
// m_axis   out  tdata: center_x center_y center_z sphere_radius[96:72]; tuser: overflow_flag
//
// each point is stored as it is accepted, and the next one may follow at once; after the last
// point three scans of the point store run (one memory read port, four-stage distance pipeline),
// the center is set before the third scan, then 26 square root steps run before the result is offered.
// reset clears the controller and the point count; the store needs no clearing.
// the result is held until m_axis_tready; no new point is taken meanwhile.
module approx_bounding_sphere (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // point_x, point_y, point_z
  input  logic         s_axis_tlast,   // last_point
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // center_x, center_y, center_z, sphere_radius, zero pad
  output logic         m_axis_tuser    // overflow_flag
);

  abs_pkg::ctrl_t  ctrl;
  abs_pkg::stat_t  stat;
  abs_pkg::point_t in_point, center;
  logic [abs_pkg::RadBits-1:0] radius;
  logic in_fire;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_point.x = s_axis_tdata[23:0];
  assign in_point.y = s_axis_tdata[47:24];
  assign in_point.z = s_axis_tdata[71:48];

  abs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .in_last_i  (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  abs_datapath u_dp (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .in_point_i(in_point),
    .stat_o    (stat),
    .center_o  (center),
    .radius_o  (radius),
    .overflow_o(m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, radius, center.z, center.y, center.x};

endmodule

// ===== tb/tb_top.sv =====
// testbench for approx_bounding_sphere: streamed point sets checked against a sphere predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  typedef struct {
    abs_pkg::coord_t              cx;
    abs_pkg::coord_t              cy;
    abs_pkg::coord_t              cz;
    logic [abs_pkg::RadBits-1:0]  rad;
    logic                         ovf;
  } sphere_t;

  class sphere_scoreboard;
    abs_pkg::point_t set_pts[abs_pkg::MaxPoints];
    int      set_len;
    bit      set_ovf;
    sphere_t expected_spheres[$];
    int      mismatches;
    int      results_seen;

    function longint unsigned dist2(abs_pkg::point_t a, abs_pkg::point_t b);
      longint dx, dy, dz;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // earliest strictly farthest point, origin kept on ties
    function abs_pkg::point_t farthest(abs_pkg::point_t origin);
      abs_pkg::point_t far_pt;
      longint unsigned best, d;
      far_pt = origin;
      best = 0;
      for (int i = 0; i < set_len; i++) begin
        d = dist2(set_pts[i], origin);
        if (d > best) begin
          best = d;
          far_pt = set_pts[i];
        end
      end
      return far_pt;
    endfunction

    function void note_point(abs_pkg::point_t p, bit last);
      abs_pkg::point_t f1, f2, ctr;
      logic signed [abs_pkg::CoordBits:0] sum;
      longint unsigned max_d, d;
      sphere_t s;
      if (set_len < abs_pkg::MaxPoints) begin
        set_pts[set_len] = p;
        set_len++;
      end else begin
        set_ovf = 1'b1;
      end
      if (!last) return;
      f1 = farthest(set_pts[0]);
      f2 = farthest(f1);
      sum = {f1.x[abs_pkg::CoordBits-1], f1.x} + {f2.x[abs_pkg::CoordBits-1], f2.x};
      ctr.x = abs_pkg::CoordBits'(sum >>> 1);
      sum = {f1.y[abs_pkg::CoordBits-1], f1.y} + {f2.y[abs_pkg::CoordBits-1], f2.y};
      ctr.y = abs_pkg::CoordBits'(sum >>> 1);
      sum = {f1.z[abs_pkg::CoordBits-1], f1.z} + {f2.z[abs_pkg::CoordBits-1], f2.z};
      ctr.z = abs_pkg::CoordBits'(sum >>> 1);
      max_d = 0;
      for (int i = 0; i < set_len; i++) begin
        d = dist2(set_pts[i], ctr);
        if (d > max_d) max_d = d;
      end
      s.cx = ctr.x;
      s.cy = ctr.y;
      s.cz = ctr.z;
      s.rad = abs_pkg::RadBits'(int_sqrt(max_d));
      s.ovf = set_ovf;
      expected_spheres.insert(expected_spheres.size(), s);
      set_len = 0;
      set_ovf = 1'b0;
    endfunction

    function void check_result(logic [103:0] data, logic user);
      sphere_t e;
      results_seen++;
      if (expected_spheres.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: tdata=%h", data);
        return;
      end
      e = expected_spheres.pop_front();
      if (data[23:0] !== e.cx || data[47:24] !== e.cy || data[71:48] !== e.cz ||
          data[96:72] !== e.rad || user !== e.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: exp c=(%0d,%0d,%0d) r=%0d ovf=%0b ",
                    "got c=(%0d,%0d,%0d) r=%0d ovf=%0b"},
                   results_seen, e.cx, e.cy, e.cz, e.rad, e.ovf,
                   $signed(data[23:0]), $signed(data[47:24]), $signed(data[71:48]),
                   data[96:72], user);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;

  sphere_scoreboard sb;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  hold_go = 0;
  bit  hold_done = 0;
  int  hold_cnt = 0;
  int  rx_mode = 0;
  int  rx_tick = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  approx_bounding_sphere dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  // receiver: ready from a periodically redrawn mode, one long hold-off on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_go && !hold_done && hold_cnt == 0) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_point(abs_pkg::point_t p, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_point(p, last);
    burst_left--;
  endtask

  function automatic abs_pkg::coord_t rand_coord(int kind);
    case (kind)
      0: return abs_pkg::coord_t'(int'($urandom_range(0, 2)) - 1);
      1: return ($urandom_range(0, 1)) ? abs_pkg::coord_t'(24'h7fffff)
                                       : abs_pkg::coord_t'(24'h800000);
      default: return abs_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic send_set(int len, int kind);
    abs_pkg::point_t p;
    for (int i = 0; i < len; i++) begin
      p.x = rand_coord(kind == 3 ? $urandom_range(0, 2) : kind);
      p.y = rand_coord(kind == 3 ? $urandom_range(0, 2) : kind);
      p.z = rand_coord(kind == 3 ? $urandom_range(0, 2) : kind);
      send_point(p, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single points at both extremes
    send_point('{z: 24'h7fffff, y: 24'h7fffff, x: 24'h7fffff}, 1);
    send_point('{z: 24'h800000, y: 24'h800000, x: 24'h800000}, 1);
    // opposite corners: widest distance, negative odd midpoint
    send_point('{z: 24'h800000, y: 24'h7fffff, x: 24'h800000}, 0);
    send_point('{z: 24'h7fffff, y: 24'h800000, x: 24'h7fffff}, 1);
    // all points equal
    repeat (3) send_point('{z: -24'sd5, y: 24'sd17, x: -24'sd3}, 0);
    send_point('{z: -24'sd5, y: 24'sd17, x: -24'sd3}, 1);
    // ties around the origin, earlier point wins
    send_point('{z: 24'sd0, y: 24'sd0, x: 24'sd0}, 0);
    send_point('{z: 24'sd0, y: 24'sd0, x: 24'sd1}, 0);
    send_point('{z: 24'sd0, y: 24'sd0, x: -24'sd1}, 0);
    send_point('{z: 24'sd0, y: 24'sd1, x: 24'sd0}, 0);
    send_point('{z: -24'sd1, y: 24'sd0, x: 24'sd0}, 1);
    // midpoint rounding toward minus infinity
    send_point('{z: -24'sd3, y: -24'sd1, x: -24'sd3}, 0);
    send_point('{z: 24'sd0, y: 24'sd0, x: 24'sd0}, 1);

    sent = 15;
    while (sent < 435) begin
      int len;
      if (sent > 150) hold_go = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      send_set(len, $urandom_range(0, 3));
      sent += len;
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (sb.expected_spheres.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_spheres.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/abs_pkg.sv
rtl/abs_datapath.sv
rtl/abs_ctrl.sv
rtl/approx_bounding_sphere.sv
tb/tb_top.sv
